### hw/rtl/edts_pkg.sv
`timescale 1ns / 1ps

package edts_pkg;

   // Field widths of the request and response beats
   localparam int ACTION_W = 2;
   localparam int FLOOR_W  = 5;
   localparam int STATE_W  = 2;
   localparam int TARGET_W = 5;

   // Default number of served floors
   localparam int FLOORS_DEFAULT = 16;

   // Request actions
   localparam logic [ACTION_W-1:0] ACT_CAR    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_UP     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DOWN   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_DECIDE = 2'd3;

   // Car motion states
   localparam logic [STATE_W-1:0] ST_UP     = 2'd0;
   localparam logic [STATE_W-1:0] ST_DOWN   = 2'd1;
   localparam logic [STATE_W-1:0] ST_VACANT = 2'd2;
   localparam logic [STATE_W-1:0] ST_PAUSE  = 2'd3;

   // Outcome of one decision, handed from the decision logic to the top level
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic                announced;
      logic                idle;
   } edts_result_type;

endpackage

### hw/rtl/edts_decide.sv
`timescale 1ns / 1ps

module edts_decide #(
   parameter int FLOORS = edts_pkg::FLOORS_DEFAULT
) (
   input  logic [edts_pkg::ACTION_W-1:0] action,
   input  logic [edts_pkg::FLOOR_W-1:0]  button_floor,
   input  logic [edts_pkg::STATE_W-1:0]  car_state,
   input  logic [edts_pkg::STATE_W-1:0]  previous_state,
   input  logic [edts_pkg::FLOOR_W-1:0]  current_floor,
   input  logic [FLOORS-1:0]             car_map,
   input  logic [FLOORS-1:0]             up_map,
   input  logic [FLOORS-1:0]             down_map,
   input  logic                          idle_flag,
   input  logic [edts_pkg::TARGET_W-1:0] last_target,
   output logic [FLOORS-1:0]             car_map_next,
   output logic [FLOORS-1:0]             up_map_next,
   output logic [FLOORS-1:0]             down_map_next,
   output edts_pkg::edts_result_type     result
);
   import edts_pkg::*;

   // Floor numbers up to FLOORS need this many bits; compare at least at field width
   localparam int NUM_W = $clog2(FLOORS + 1);
   localparam int CMP_W = (NUM_W > FLOOR_W) ? NUM_W : FLOOR_W;

   logic [CMP_W-1:0]  cur_ext;
   logic [CMP_W-1:0]  btn_ext;
   logic [FLOORS-1:0] cur_bit;
   logic [FLOORS-1:0] btn_bit;
   logic [FLOORS-1:0] ge_mask;
   logic [FLOORS-1:0] gt_mask;
   logic [FLOORS-1:0] le_mask;
   logic [FLOORS-1:0] lt_mask;
   logic              cur_above_one;
   logic              cur_below_top;

   // Lowest floor with a bit set, zero when none
   function automatic logic [CMP_W-1:0] find_low(input logic [FLOORS-1:0] m);
      logic [CMP_W-1:0] r;
      r = '0;
      for (int i = FLOORS - 1; i >= 0; i--) begin
         if (m[i]) begin
            r = CMP_W'(i + 1);
         end
      end
      return r;
   endfunction

   // Highest floor with a bit set, zero when none
   function automatic logic [CMP_W-1:0] find_high(input logic [FLOORS-1:0] m);
      logic [CMP_W-1:0] r;
      r = '0;
      for (int i = 0; i < FLOORS; i++) begin
         if (m[i]) begin
            r = CMP_W'(i + 1);
         end
      end
      return r;
   endfunction

   assign cur_ext       = CMP_W'(current_floor);
   assign btn_ext       = CMP_W'(button_floor);
   assign cur_above_one = cur_ext > CMP_W'(1);
   assign cur_below_top = cur_ext < CMP_W'(FLOORS);

   // Build per-floor masks relative to the car and the pressed button
   always_comb begin
      for (int i = 0; i < FLOORS; i++) begin
         cur_bit[i] = (CMP_W'(i + 1) == cur_ext);
         btn_bit[i] = (CMP_W'(i + 1) == btn_ext);
         ge_mask[i] = (CMP_W'(i + 1) >= cur_ext);
         gt_mask[i] = (CMP_W'(i + 1) >  cur_ext);
         le_mask[i] = (CMP_W'(i + 1) <= cur_ext);
         lt_mask[i] = (CMP_W'(i + 1) <  cur_ext);
      end
   end

   // Apply a press or a decision to the maps and pick the target
   always_comb begin
      logic [FLOORS-1:0] car_c;
      logic [FLOORS-1:0] up_c;
      logic [FLOORS-1:0] down_c;
      logic [CMP_W-1:0]  f;

      car_c            = car_map;
      up_c             = up_map;
      down_c           = down_map;
      f                = '0;
      result.target    = last_target;
      result.announced = 1'b0;
      result.idle      = idle_flag;

      case (action)
         ACT_CAR: begin
            car_c = car_map | btn_bit;
         end
         ACT_UP: begin
            up_c = up_map | btn_bit;
         end
         ACT_DOWN: begin
            down_c = down_map | btn_bit;
         end
         default: begin
            case (car_state)
               ST_UP: begin
                  f = find_low((up_map | car_map) & ge_mask);
                  if (f != '0) begin
                     result.target = f[TARGET_W-1:0];
                  end
               end
               ST_DOWN: begin
                  f = find_high((down_map | car_map) & le_mask);
                  if (f != '0) begin
                     result.target = f[TARGET_W-1:0];
                  end
               end
               ST_VACANT: begin
                  // Announce idle once and drop the current floor's calls
                  if (!idle_flag) begin
                     result.announced = 1'b1;
                     car_c            = car_map & ~cur_bit;
                     up_c             = up_map & ~cur_bit;
                     down_c           = down_map & ~cur_bit;
                  end
                  f             = find_low(car_c | up_c | down_c);
                  result.idle   = (f == '0);
                  result.target = f[TARGET_W-1:0];
               end
               default: begin
                  car_c = car_map & ~cur_bit;
                  case (previous_state)
                     ST_UP: begin
                        // Serve calls above first, then reverse
                        up_c = up_map & ~cur_bit;
                        f    = find_low((car_c | up_c) & gt_mask);
                        if (f == '0 && cur_above_one) begin
                           f = find_high((down_map | car_c) & le_mask);
                        end
                        result.target = f[TARGET_W-1:0];
                     end
                     ST_DOWN: begin
                        // Serve calls below first, then reverse
                        down_c = down_map & ~cur_bit;
                        if (cur_above_one) begin
                           f = find_high((down_c | car_c) & lt_mask);
                        end
                        if (f != '0) begin
                           result.target = f[TARGET_W-1:0];
                        end else if (cur_below_top) begin
                           f             = find_low((car_c | up_map) & ge_mask);
                           result.target = f[TARGET_W-1:0];
                        end
                     end
                     ST_PAUSE: begin
                        up_c          = up_map & ~cur_bit;
                        down_c        = down_map & ~cur_bit;
                        result.target = '0;
                     end
                     default: begin
                        // After vacant: keep the target
                     end
                  endcase
               end
            endcase
         end
      endcase

      car_map_next  = car_c;
      up_map_next   = up_c;
      down_map_next = down_c;
   end

endmodule

### hw/rtl/elevator_direction_target_select.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  action, button_floor, car_state,
//                                             previous_state, current_floor
// rsp_      out        rsp_valid / rsp_stall  target_floor, idle_announced
//
// One request beat is taken every cycle unless req_stall is high. A beat waits in
// the input register, then the decision logic updates the request maps and, for a
// decide beat, loads the response register. Press beats give no response. A
// stalled response holds the decide beat behind it in the input register; press
// beats pass regardless.
// Synchronous reset clears the request maps, the idle flag and the target.

module elevator_direction_target_select #(
   parameter int FLOORS = edts_pkg::FLOORS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [edts_pkg::ACTION_W-1:0] req_action,
   input  logic [edts_pkg::FLOOR_W-1:0]  req_button_floor,
   input  logic [edts_pkg::STATE_W-1:0]  req_car_state,
   input  logic [edts_pkg::STATE_W-1:0]  req_previous_state,
   input  logic [edts_pkg::FLOOR_W-1:0]  req_current_floor,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [edts_pkg::TARGET_W-1:0] rsp_target_floor,
   output logic                          rsp_idle_announced
);
   import edts_pkg::*;

   logic                s1_valid_ff, s1_valid_in;
   logic [ACTION_W-1:0] s1_action_ff;
   logic [FLOOR_W-1:0]  s1_button_ff;
   logic [STATE_W-1:0]  s1_state_ff;
   logic [STATE_W-1:0]  s1_prev_ff;
   logic [FLOOR_W-1:0]  s1_cur_ff;

   logic [FLOORS-1:0]   car_ff, car_in;
   logic [FLOORS-1:0]   up_ff, up_in;
   logic [FLOORS-1:0]   down_ff, down_in;
   logic                idle_ff;
   logic [TARGET_W-1:0] target_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TARGET_W-1:0] rsp_target_ff;
   logic                rsp_announced_ff;

   edts_result_type     result;
   logic                out_free;
   logic                s1_decide;
   logic                s1_fire;
   logic                req_take;

   // Handshake: a decide beat moves on only when the response register frees up
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_decide = (s1_action_ff == ACT_DECIDE);
   assign s1_fire   = s1_valid_ff && (!s1_decide || out_free);
   assign req_stall = s1_valid_ff && !s1_fire;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && s1_decide) ? 1'b1 :
                         (rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff;

   edts_decide #(
      .FLOORS(FLOORS)
   ) u_decide (
      .action        (s1_action_ff),
      .button_floor  (s1_button_ff),
      .car_state     (s1_state_ff),
      .previous_state(s1_prev_ff),
      .current_floor (s1_cur_ff),
      .car_map       (car_ff),
      .up_map        (up_ff),
      .down_map      (down_ff),
      .idle_flag     (idle_ff),
      .last_target   (target_ff),
      .car_map_next  (car_in),
      .up_map_next   (up_in),
      .down_map_next (down_in),
      .result        (result)
   );

   // Control state: beat valids, request maps, idle flag, target
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         car_ff       <= '0;
         up_ff        <= '0;
         down_ff      <= '0;
         idle_ff      <= 1'b0;
         target_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            car_ff    <= car_in;
            up_ff     <= up_in;
            down_ff   <= down_in;
            idle_ff   <= result.idle;
            target_ff <= result.target;
         end
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_action_ff <= req_action;
         s1_button_ff <= req_button_floor;
         s1_state_ff  <= req_car_state;
         s1_prev_ff   <= req_previous_state;
         s1_cur_ff    <= req_current_floor;
      end
   end

   // Load the response beat; hold it while stalled
   always_ff @(posedge clock) begin
      if (s1_fire && s1_decide) begin
         rsp_target_ff    <= result.target;
         rsp_announced_ff <= result.announced;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_floor   = rsp_target_ff;
   assign rsp_idle_announced = rsp_announced_ff;

endmodule

### hw/rtl/edts_checker.sv
`timescale 1ns / 1ps

module edts_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [edts_pkg::ACTION_W-1:0] req_action,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [edts_pkg::TARGET_W-1:0] rsp_target_floor,
   input logic                          rsp_idle_announced
);
   import edts_pkg::*;

   // Reset empties the response register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_target_floor)
                                 && $stable(rsp_idle_announced))
      else $error("stalled response changed");

   // With the response register empty, requests never stall
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty response register");

   // A fresh response comes from a decide beat taken earlier, via the input and response registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_action == ACT_DECIDE, 2))
      else $error("response without a matching decide beat");

endmodule

bind elevator_direction_target_select edts_checker u_edts_checker (.*);

### tb/tb_elevator_direction_target_select.sv
`timescale 1ns / 1ps

module tb_elevator_direction_target_select;
   import edts_pkg::*;

   localparam int FLOORS      = FLOORS_DEFAULT;
   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 200;

   // One request beat as driven on the req_ ports
   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [FLOOR_W-1:0]  button;
      logic [STATE_W-1:0]  state;
      logic [STATE_W-1:0]  prev;
      logic [FLOOR_W-1:0]  cur;
   } beat_type;

   // One predicted response beat
   typedef struct {
      logic [TARGET_W-1:0] target;
      logic                announced;
   } target_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [ACTION_W-1:0] req_action = ACT_CAR;
   logic [FLOOR_W-1:0]  req_button_floor = '0;
   logic [STATE_W-1:0]  req_car_state = ST_UP;
   logic [STATE_W-1:0]  req_previous_state = ST_UP;
   logic [FLOOR_W-1:0]  req_current_floor = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [TARGET_W-1:0] rsp_target_floor;
   logic                rsp_idle_announced;

   // Predictor state: call maps indexed by floor, idle flag and held target
   logic [FLOORS:1]     car_calls;
   logic [FLOORS:1]     up_calls;
   logic [FLOORS:1]     down_calls;
   logic                idle_seen;
   logic [TARGET_W-1:0] held_target;
   target_type          pending_targets[$];

   bit req_idle_on;
   bit rsp_idle_on;
   int hold_requests = 0;
   int holds_started = 0;
   int hold_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int n_beats;
   int n_decisions;
   int n_announce;
   int n_checked = 0;
   int n_errors = 0;

   elevator_direction_target_select #(
      .FLOORS(FLOORS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_button_floor(req_button_floor),
      .req_car_state(req_car_state),
      .req_previous_state(req_previous_state),
      .req_current_floor(req_current_floor),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_target_floor(rsp_target_floor),
      .rsp_idle_announced(rsp_idle_announced)
   );

   always #6 clock = ~clock;

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(bit on);
      int r;
      if (!on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ACTION_W-1:0] random_press_action();
      return ACTION_W'($urandom_range(int'(ACT_CAR), int'(ACT_DOWN)));
   endfunction

   function automatic logic [STATE_W-1:0] random_state();
      return STATE_W'($urandom_range(int'(ST_UP), int'(ST_PAUSE)));
   endfunction

   function automatic logic [FLOORS:1] drop_floor(logic [FLOORS:1] m, int f);
      if (f >= 1 && f <= FLOORS) m[f] = 1'b0;
      return m;
   endfunction

   // Lowest floor in [lo, hi] with a call, 0 when none
   function automatic int lowest_call(logic [FLOORS:1] m, int lo, int hi);
      int f;
      if (lo < 1) lo = 1;
      if (hi > FLOORS) hi = FLOORS;
      for (f = lo; f <= hi; f++)
         if (m[f]) return f;
      return 0;
   endfunction

   // Highest floor in [lo, hi] with a call, 0 when none
   function automatic int highest_call(logic [FLOORS:1] m, int lo, int hi);
      int f;
      if (lo < 1) lo = 1;
      if (hi > FLOORS) hi = FLOORS;
      for (f = hi; f >= lo; f--)
         if (m[f]) return f;
      return 0;
   endfunction

   // Update the call maps for one accepted beat and, for a decide beat, queue the target it yields
   function automatic void predict_target(beat_type b);
      int         f;
      int         cur;
      target_type t;
      cur = int'(b.cur);
      t.announced = 1'b0;
      if (b.action != ACT_DECIDE) begin
         if (b.button >= 1 && b.button <= FLOORS) begin
            case (b.action)
               ACT_CAR: car_calls[b.button] = 1'b1;
               ACT_UP:  up_calls[b.button] = 1'b1;
               default: down_calls[b.button] = 1'b1;
            endcase
         end
         return;
      end
      case (b.state)
         ST_UP: begin
            f = lowest_call(up_calls | car_calls, cur, FLOORS);
            if (f != 0) held_target = f[TARGET_W-1:0];
         end
         ST_DOWN: begin
            f = highest_call(down_calls | car_calls, 1, cur);
            if (f != 0) held_target = f[TARGET_W-1:0];
         end
         ST_VACANT: begin
            // announce idle once and clear the floor the car stands at
            if (!idle_seen) begin
               t.announced = 1'b1;
               car_calls = drop_floor(car_calls, cur);
               up_calls = drop_floor(up_calls, cur);
               down_calls = drop_floor(down_calls, cur);
               idle_seen = 1'b1;
            end
            f = lowest_call(car_calls | up_calls | down_calls, 1, FLOORS);
            if (f != 0) idle_seen = 1'b0;
            held_target = f[TARGET_W-1:0];
         end
         default: begin
            car_calls = drop_floor(car_calls, cur);
            case (b.prev)
               ST_UP: begin
                  // serve onward calls first, then reverse
                  up_calls = drop_floor(up_calls, cur);
                  f = lowest_call(car_calls | up_calls, cur + 1, FLOORS);
                  if (f == 0 && cur > 1) f = highest_call(down_calls | car_calls, 1, cur);
                  held_target = f[TARGET_W-1:0];
               end
               ST_DOWN: begin
                  down_calls = drop_floor(down_calls, cur);
                  f = 0;
                  if (cur > 1) f = highest_call(down_calls | car_calls, 1, cur - 1);
                  if (f != 0) begin
                     held_target = f[TARGET_W-1:0];
                  end else if (cur < FLOORS) begin
                     f = lowest_call(car_calls | up_calls, cur, FLOORS);
                     held_target = f[TARGET_W-1:0];
                  end
               end
               ST_PAUSE: begin
                  up_calls = drop_floor(up_calls, cur);
                  down_calls = drop_floor(down_calls, cur);
                  held_target = '0;
               end
               default: ;
            endcase
         end
      endcase
      t.target = held_target;
      pending_targets.push_back(t);
      n_decisions++;
      if (t.announced) n_announce++;
   endfunction

   function automatic beat_type make_press(logic [ACTION_W-1:0] act, int fl);
      beat_type b;
      b.action = act;
      b.button = FLOOR_W'(fl);
      b.state = random_state();
      b.prev = random_state();
      b.cur = FLOOR_W'($urandom_range(0, 31));
      return b;
   endfunction

   function automatic beat_type make_decide(logic [STATE_W-1:0] st, logic [STATE_W-1:0] pv,
                                            int cur);
      beat_type b;
      b.action = ACT_DECIDE;
      b.button = FLOOR_W'($urandom_range(0, 31));
      b.state = st;
      b.prev = pv;
      b.cur = FLOOR_W'(cur);
      return b;
   endfunction

   // Mostly in-range presses and decides, some floors outside 1..FLOORS
   function automatic beat_type random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return make_press(random_press_action(), $urandom_range(1, FLOORS));
      if (r < 62) return make_press(random_press_action(), $urandom_range(0, 31));
      if (r < 92) return make_decide(random_state(), random_state(), $urandom_range(1, FLOORS));
      return make_decide(random_state(), random_state(), $urandom_range(0, 31));
   endfunction

   // Offer one beat after a random gap, hold it until accepted, then predict
   task automatic send_beat(beat_type b);
      int gap;
      gap = pick_gap(req_idle_on);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= b.action;
      req_button_floor <= b.button;
      req_car_state <= b.state;
      req_previous_state <= b.prev;
      req_current_floor <= b.cur;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_beats++;
      predict_target(b);
   endtask

   task automatic note_mismatch(string what, int want, int got);
      n_errors++;
      if (n_errors <= 10)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endtask

   // Extremes of the fields, every action and every state
   task automatic test_directed();
      send_beat(make_decide(ST_VACANT, ST_UP, 5));
      send_beat(make_decide(ST_VACANT, ST_DOWN, 5));
      send_beat(make_press(ACT_CAR, FLOORS));
      send_beat(make_press(ACT_UP, 1));
      send_beat(make_press(ACT_DOWN, 8));
      send_beat(make_press(ACT_CAR, 0));
      send_beat(make_press(ACT_UP, 31));
      send_beat(make_press(ACT_DOWN, FLOORS + 1));
      send_beat(make_decide(ST_UP, ST_UP, 1));
      send_beat(make_decide(ST_UP, ST_VACANT, 2));
      send_beat(make_decide(ST_DOWN, ST_DOWN, FLOORS));
      send_beat(make_decide(ST_DOWN, ST_PAUSE, 7));
      send_beat(make_decide(ST_PAUSE, ST_UP, FLOORS));
      send_beat(make_decide(ST_PAUSE, ST_DOWN, 8));
      send_beat(make_press(ACT_UP, 3));
      send_beat(make_press(ACT_CAR, 12));
      send_beat(make_decide(ST_PAUSE, ST_VACANT, 3));
      send_beat(make_decide(ST_PAUSE, ST_PAUSE, 3));
      send_beat(make_decide(ST_VACANT, ST_PAUSE, 12));
      send_beat(make_decide(ST_VACANT, ST_PAUSE, 12));
      send_beat(make_press(ACT_DOWN, FLOORS));
      send_beat(make_decide(ST_PAUSE, ST_DOWN, FLOORS));
      send_beat(make_decide(ST_PAUSE, ST_DOWN, 1));
      send_beat(make_decide(ST_UP, ST_DOWN, 0));
      send_beat(make_decide(ST_DOWN, ST_UP, 31));
   endtask

   // Drive the car like a real dispatcher would: call, move floor by floor, stop
   task automatic test_trips();
      int                 cur;
      int                 steps;
      logic [STATE_W-1:0] heading;
      cur = $urandom_range(1, FLOORS);
      heading = ST_UP;
      repeat (25) begin
         repeat ($urandom_range(1, 4))
            send_beat(make_press(random_press_action(), $urandom_range(1, FLOORS)));
         send_beat(make_decide(ST_VACANT, ST_PAUSE, cur));
         steps = 0;
         while (held_target != 0 && steps < 48) begin
            if (held_target == cur) begin
               send_beat(make_decide(ST_PAUSE, heading, cur));
               // still targeting this floor: stop once more facing the other way
               if (held_target == cur) heading = (heading == ST_UP) ? ST_DOWN : ST_UP;
            end else begin
               heading = (held_target > cur) ? ST_UP : ST_DOWN;
               cur = (heading == ST_UP) ? cur + 1 : cur - 1;
               if ($urandom_range(0, 4) == 0)
                  send_beat(make_press(random_press_action(), $urandom_range(1, FLOORS)));
               send_beat(make_decide(heading, heading, cur));
            end
            steps++;
         end
      end
   endtask

   task automatic test_random_mix();
      repeat (500) send_beat(random_beat());
   endtask

   // Hold the response side off while beats keep coming, so the input backs up
   task automatic test_back_pressure();
      req_idle_on = 1'b0;
      hold_requests++;
      repeat (80) send_beat(random_beat());
      req_idle_on = 1'b1;
   endtask

   task automatic test_full_rate();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (200) send_beat(random_beat());
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // Receiver stalls: a requested hold first, then random bursts
   always @(posedge clock) begin
      if (hold_requests != holds_started) begin
         holds_started = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = pick_gap(rsp_idle_on);
      end
   end

   // Compare each accepted response beat with the oldest predicted target
   always @(posedge clock) begin : check_response
      target_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_targets.size() == 0) begin
            note_mismatch("unexpected response, target", -1, int'(rsp_target_floor));
         end else begin
            want = pending_targets.pop_front();
            n_checked++;
            if (rsp_target_floor !== want.target)
               note_mismatch("target_floor", int'(want.target), int'(rsp_target_floor));
            if (rsp_idle_announced !== want.announced)
               note_mismatch("idle_announced", int'(want.announced),
                             int'(rsp_idle_announced));
         end
      end
   end

   // Stop a hung run: count cycles in which neither channel moves a beat
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      car_calls = '0;
      up_calls = '0;
      down_calls = '0;
      idle_seen = 1'b0;
      held_target = '0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      n_beats = 0;
      n_decisions = 0;
      n_announce = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_trips();
      test_random_mix();
      test_back_pressure();
      test_full_rate();

      // drain outstanding responses, then watch for strays
      req_valid <= 1'b0;
      while (pending_targets.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("sent %0d request beats with directed, trip, random, back-pressure", n_beats);
      $display("and full-rate phases; checked %0d of %0d decisions, %0d idle announcements",
               n_checked, n_decisions, n_announce);
      if (n_errors == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", n_errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule
